// ===== design/bass_pkg.sv =====
// Shared types, constants and weight tables of the avoidance speed selector.
package bass_pkg;

    // Frame geometry
    localparam int SENSOR_COUNT = 8;
    localparam int SAMPLE_BITS  = 12;
    localparam int MIG_W        = 13;
    localparam int OUT_W        = 15;
    localparam int THR_W        = 12;
    localparam int OFS_W        = 9;
    localparam int WGT_W        = 8;

    // Datapath widths
    localparam int PROD_W = SAMPLE_BITS + WGT_W;   // one weighted sample
    localparam int SUM_W  = PROD_W + 3;            // sum over eight lanes
    localparam int MAG_W  = SUM_W - 1;             // magnitude of a sum
    localparam int Q_W    = MAG_W - 8;             // quotient by 350
    localparam int SPD_W  = 14;                    // selected wheel demand
    localparam int LIM_W  = 17;                    // limiter working width

    // Division by 350: multiply by ceil(2^28 / 350) and shift
    localparam int RECIP_W   = 20;
    localparam int DIV_SHIFT = 28;
    localparam logic [RECIP_W-1:0] RECIP_350 = 20'd766959;

    // Register map (word index)
    localparam logic [2:0] REG_ENTER = 3'd0;
    localparam logic [2:0] REG_EXIT  = 3'd1;
    localparam logic [2:0] REG_LIMIT = 3'd2;
    localparam logic [2:0] REG_LOFS  = 3'd3;
    localparam logic [2:0] REG_ROFS  = 3'd4;

    // Reset values
    localparam logic [THR_W-1:0]        ENTER_RST = 12'd1000;
    localparam logic [THR_W-1:0]        EXIT_RST  = 12'd70;
    localparam logic [THR_W-1:0]        LIMIT_RST = 12'd800;
    localparam logic signed [OFS_W-1:0] LOFS_RST  = 9'sd66;
    localparam logic signed [OFS_W-1:0] ROFS_RST  = 9'sd72;

    typedef logic signed [WGT_W-1:0]  weight_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef prod_t [SENSOR_COUNT-1:0] prod_vec_t;

    // Weight tables, sensor 0 first
    localparam weight_t RIGHT_W [SENSOR_COUNT] = '{
        8'sd17, 8'sd29, 8'sd34, 8'sd10, 8'sd8, -8'sd38, -8'sd56, -8'sd76
    };
    localparam weight_t LEFT_W [SENSOR_COUNT] = '{
        -8'sd72, -8'sd58, -8'sd36, 8'sd8, 8'sd10, 8'sd36, 8'sd28, 8'sd18
    };

    // What one lane reports for its sample
    typedef struct packed {
        prod_t prod_l;
        prod_t prod_r;
        logic  above_enter;
        logic  below_exit;
    } lane_out_t;

    // Scaled sum: sign and truncated quotient magnitude
    typedef struct packed {
        logic           neg;
        logic [Q_W-1:0] quo;
    } scaled_t;

endpackage

// ===== design/braitenberg_avoid_speed_select.sv =====
// Top level of the avoidance speed selector: register port, pipeline, mode.
//
// Input stream s_*: one item per frame carrying eight 12-bit proximity samples
// and the two 13-bit signed migration wheel demands. Result stream m_*: the
// limited left and right wheel speeds in tdata, the avoiding flag in tuser.
// Every accepted item gives exactly one result, in order.
// The pipeline has five stages (lane products, lane merge, divide by 350,
// offset and mode select, limiter into the output register). One item per
// cycle is sustained while the receiver takes results; the rate is set by the
// avoidance mode update done at acceptance from the lane compares.
// Each stage holds when the one after it is full and stalled, so a stalled
// receiver first lets the empty stages fill; s_tready falls only when all
// five stages hold items. The user writes registers through the APB port only
// while the block is idle; the block does not enforce it. Reset (aresetn low,
// synchronous) empties the pipeline, restores the register defaults and puts
// the block in migration mode.
module braitenberg_avoid_speed_select (
    input  logic         aclk,
    input  logic         aresetn,
    // APB register port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // Input items
    input  logic         s_tvalid,
    output logic         s_tready,
    // sensor_0..sensor_7 (12 b each), migrate_left (13 b), migrate_right (13 b)
    input  logic [127:0] s_tdata,
    // Result items
    output logic         m_tvalid,
    input  logic         m_tready,
    // left_speed (15 b), right_speed (15 b)
    output logic [31:0]  m_tdata,
    // avoiding (1 b)
    output logic [0:0]   m_tuser
);
    import bass_pkg::*;

    // Configuration registers
    logic [THR_W-1:0]        enter_thr_reg;
    logic [THR_W-1:0]        exit_thr_reg;
    logic [THR_W-1:0]        limit_reg;
    logic signed [OFS_W-1:0] lofs_reg;
    logic signed [OFS_W-1:0] rofs_reg;
    logic                    cfg_wr;
    logic [2:0]              cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enter_thr_reg <= ENTER_RST;
            exit_thr_reg  <= EXIT_RST;
            limit_reg     <= LIMIT_RST;
            lofs_reg      <= LOFS_RST;
            rofs_reg      <= ROFS_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_ENTER: enter_thr_reg <= pwdata[THR_W-1:0];
                REG_EXIT:  exit_thr_reg  <= pwdata[THR_W-1:0];
                REG_LIMIT: limit_reg     <= pwdata[THR_W-1:0];
                REG_LOFS:  lofs_reg      <= $signed(pwdata[OFS_W-1:0]);
                REG_ROFS:  rofs_reg      <= $signed(pwdata[OFS_W-1:0]);
                default: ;
            endcase
        end
    end

    // Register read-back
    always_comb begin
        unique case (cfg_idx)
            REG_ENTER: prdata = {{(32-THR_W){1'b0}}, enter_thr_reg};
            REG_EXIT:  prdata = {{(32-THR_W){1'b0}}, exit_thr_reg};
            REG_LIMIT: prdata = {{(32-THR_W){1'b0}}, limit_reg};
            REG_LOFS:  prdata = {{(32-OFS_W){1'b0}}, lofs_reg};
            REG_ROFS:  prdata = {{(32-OFS_W){1'b0}}, rofs_reg};
            default:   prdata = '0;
        endcase
    end

    // Unpack the input item
    logic [SAMPLE_BITS-1:0]  samples [SENSOR_COUNT];
    logic signed [MIG_W-1:0] mig_l_in;
    logic signed [MIG_W-1:0] mig_r_in;

    always_comb begin
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            samples[i] = s_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
        end
    end
    assign mig_l_in = $signed(s_tdata[SENSOR_COUNT*SAMPLE_BITS +: MIG_W]);
    assign mig_r_in = $signed(s_tdata[SENSOR_COUNT*SAMPLE_BITS+MIG_W +: MIG_W]);

    // Sensor lanes
    lane_out_t lanes [SENSOR_COUNT];
    logic [SENSOR_COUNT-1:0] below_vec;

    for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_lane
        bass_lane u_lane (
            .sample    (samples[g]),
            .weight_l  (LEFT_W[g]),
            .weight_r  (RIGHT_W[g]),
            .enter_thr (enter_thr_reg),
            .exit_thr  (exit_thr_reg),
            .lane_out  (lanes[g])
        );
        assign below_vec[g] = lanes[g].below_exit;
    end

    // Pipeline handshake: a stage loads when it is empty or the next one moves
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic acc;

    assign rdy5     = !v5_reg || m_tready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign acc      = s_tvalid && rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // Avoidance mode: enter on a front hit, leave when every sample is low
    logic mode_reg;
    logic front_hit;
    logic all_low;
    logic avoid_now;

    assign front_hit = lanes[0].above_enter || lanes[1].above_enter ||
                       lanes[6].above_enter || lanes[7].above_enter;
    assign all_low   = &below_vec;
    assign avoid_now = mode_reg || front_hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
        end else if (acc) begin
            mode_reg <= avoid_now && !all_low;
        end
    end

    // Stage 1: lane products
    prod_vec_t               prods_l_reg;
    prod_vec_t               prods_r_reg;
    logic                    av1_reg;
    logic signed [MIG_W-1:0] mig_l1_reg, mig_r1_reg;

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                prods_l_reg[i] <= lanes[i].prod_l;
                prods_r_reg[i] <= lanes[i].prod_r;
            end
            av1_reg    <= avoid_now;
            mig_l1_reg <= mig_l_in;
            mig_r1_reg <= mig_r_in;
        end
    end

    // Stage 2: merged sums
    sum_t                    sum_l, sum_r;
    sum_t                    sum_l2_reg, sum_r2_reg;
    logic                    av2_reg;
    logic signed [MIG_W-1:0] mig_l2_reg, mig_r2_reg;

    bass_merge u_merge (
        .prods_l (prods_l_reg),
        .prods_r (prods_r_reg),
        .sum_l   (sum_l),
        .sum_r   (sum_r)
    );

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            sum_l2_reg <= sum_l;
            sum_r2_reg <= sum_r;
            av2_reg    <= av1_reg;
            mig_l2_reg <= mig_l1_reg;
            mig_r2_reg <= mig_r1_reg;
        end
    end

    // Stage 3: divide by 350
    scaled_t                 sc_l, sc_r;
    scaled_t                 sc_l3_reg, sc_r3_reg;
    logic                    av3_reg;
    logic signed [MIG_W-1:0] mig_l3_reg, mig_r3_reg;

    bass_div350 u_div_l (.sum(sum_l2_reg), .scaled(sc_l));
    bass_div350 u_div_r (.sum(sum_r2_reg), .scaled(sc_r));

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            sc_l3_reg  <= sc_l;
            sc_r3_reg  <= sc_r;
            av3_reg    <= av2_reg;
            mig_l3_reg <= mig_l2_reg;
            mig_r3_reg <= mig_r2_reg;
        end
    end

    // Stage 4: restore sign, add offsets, pick the wheel pair
    logic signed [Q_W:0]     q_l, q_r;
    logic signed [Q_W+1:0]   avo_l, avo_r;
    logic signed [SPD_W-1:0] sel_l, sel_r;
    logic signed [SPD_W-1:0] spd_l4_reg, spd_r4_reg;
    logic                    av4_reg;

    assign q_l   = sc_l3_reg.neg ? -$signed({1'b0, sc_l3_reg.quo})
                                 :  $signed({1'b0, sc_l3_reg.quo});
    assign q_r   = sc_r3_reg.neg ? -$signed({1'b0, sc_r3_reg.quo})
                                 :  $signed({1'b0, sc_r3_reg.quo});
    assign avo_l = $signed({q_l[Q_W], q_l}) +
                   $signed({{(Q_W+2-OFS_W){lofs_reg[OFS_W-1]}}, lofs_reg});
    assign avo_r = $signed({q_r[Q_W], q_r}) +
                   $signed({{(Q_W+2-OFS_W){rofs_reg[OFS_W-1]}}, rofs_reg});
    assign sel_l = av3_reg ? avo_l[SPD_W-1:0]
                           : $signed({{(SPD_W-MIG_W){mig_l3_reg[MIG_W-1]}}, mig_l3_reg});
    assign sel_r = av3_reg ? avo_r[SPD_W-1:0]
                           : $signed({{(SPD_W-MIG_W){mig_r3_reg[MIG_W-1]}}, mig_r3_reg});

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            spd_l4_reg <= sel_l;
            spd_r4_reg <= sel_r;
            av4_reg    <= av3_reg;
        end
    end

    // Stage 5: limiter into the output register
    logic signed [OUT_W-1:0] lim_l, lim_r;
    logic signed [OUT_W-1:0] out_l_reg, out_r_reg;
    logic                    av5_reg;

    bass_limiter u_limiter (
        .left_in   (spd_l4_reg),
        .right_in  (spd_r4_reg),
        .limit     (limit_reg),
        .left_out  (lim_l),
        .right_out (lim_r)
    );

    always_ff @(posedge aclk) begin
        if (rdy5) begin
            out_l_reg <= lim_l;
            out_r_reg <= lim_r;
            av5_reg   <= av4_reg;
        end
    end

    assign m_tvalid = v5_reg;
    assign m_tdata  = {{(32-2*OUT_W){1'b0}}, out_r_reg, out_l_reg};
    assign m_tuser  = av5_reg;

    // A front hit at acceptance always marks that item as avoiding
    a_hit_avoids: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && front_hit) |=> av1_reg)
        else $error("front hit did not select avoidance");

    // Without a hit in migration mode the item stays in migration
    a_no_hit_migrates: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && !mode_reg && !front_hit) |=> !av1_reg)
        else $error("avoidance selected without a front hit");

    // All samples under the exit level leave avoidance mode
    a_exit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && all_low) |=> !mode_reg)
        else $error("avoidance mode kept after a quiet frame");

    // An empty first stage never refuses an item
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !v1_reg |-> s_tready)
        else $error("input stalled with the first stage empty");

endmodule

// ===== design/bass_lane.sv =====
// One sensor lane: weighted products and threshold compares for one sample.
module bass_lane (
    input  logic [bass_pkg::SAMPLE_BITS-1:0] sample,
    input  bass_pkg::weight_t                weight_l,
    input  bass_pkg::weight_t                weight_r,
    input  logic [bass_pkg::THR_W-1:0]       enter_thr,
    input  logic [bass_pkg::THR_W-1:0]       exit_thr,
    output bass_pkg::lane_out_t              lane_out
);
    import bass_pkg::*;

    logic signed [PROD_W-1:0] samp_x;
    logic signed [PROD_W-1:0] wl_x;
    logic signed [PROD_W-1:0] wr_x;

    // Extend operands to product width before the constant multiplies
    assign samp_x = $signed({{(PROD_W-SAMPLE_BITS){1'b0}}, sample});
    assign wl_x   = $signed({{(PROD_W-WGT_W){weight_l[WGT_W-1]}}, weight_l});
    assign wr_x   = $signed({{(PROD_W-WGT_W){weight_r[WGT_W-1]}}, weight_r});

    assign lane_out.prod_l      = samp_x * wl_x;
    assign lane_out.prod_r      = samp_x * wr_x;
    assign lane_out.above_enter = (sample > enter_thr);
    assign lane_out.below_exit  = (sample < exit_thr);

endmodule

// ===== design/bass_merge.sv =====
// Merging stage: sums the registered lane products of each wheel.
module bass_merge (
    input  bass_pkg::prod_vec_t prods_l,
    input  bass_pkg::prod_vec_t prods_r,
    output bass_pkg::sum_t      sum_l,
    output bass_pkg::sum_t      sum_r
);
    import bass_pkg::*;

    always_comb begin
        sum_t acc_l;
        sum_t acc_r;
        acc_l = '0;
        acc_r = '0;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            acc_l = acc_l + $signed({{(SUM_W-PROD_W){prods_l[i][PROD_W-1]}}, prods_l[i]});
            acc_r = acc_r + $signed({{(SUM_W-PROD_W){prods_r[i][PROD_W-1]}}, prods_r[i]});
        end
        sum_l = acc_l;
        sum_r = acc_r;
    end

endmodule

// ===== design/bass_div350.sv =====
// Truncating division of a signed sum by 350 via reciprocal multiply.
module bass_div350 (
    input  bass_pkg::sum_t  sum,
    output bass_pkg::scaled_t scaled
);
    import bass_pkg::*;

    logic                       neg;
    logic [SUM_W-1:0]           abs_v;
    logic [MAG_W-1:0]           mag;
    logic [MAG_W+RECIP_W-1:0]   prod;

    // Work on the magnitude so the quotient truncates toward zero
    assign neg   = sum[SUM_W-1];
    assign abs_v = neg ? (~sum + 1'b1) : sum;
    assign mag   = abs_v[MAG_W-1:0];

    // Exact floor for magnitudes under 2^28 / 194
    assign prod = mag * RECIP_350;

    assign scaled.neg = neg;
    assign scaled.quo = prod[DIV_SHIFT +: Q_W];

endmodule

// ===== design/bass_limiter.sv =====
// Rescaling limiter: clamps larger wheel, keeps difference if one clamps.
module bass_limiter (
    input  logic signed [bass_pkg::SPD_W-1:0] left_in,
    input  logic signed [bass_pkg::SPD_W-1:0] right_in,
    input  logic [bass_pkg::THR_W-1:0]        limit,
    output logic signed [bass_pkg::OUT_W-1:0] left_out,
    output logic signed [bass_pkg::OUT_W-1:0] right_out
);
    import bass_pkg::*;

    logic signed [LIM_W-1:0] p;
    logic signed [LIM_W-1:0] q;
    logic signed [LIM_W-1:0] lim;
    logic signed [LIM_W-1:0] nlim;
    logic signed [LIM_W-1:0] d_pq;
    logic signed [LIM_W-1:0] d_qp;
    logic signed [LIM_W-1:0] lp;
    logic signed [LIM_W-1:0] lq;

    assign p    = $signed({{(LIM_W-SPD_W){left_in[SPD_W-1]}}, left_in});
    assign q    = $signed({{(LIM_W-SPD_W){right_in[SPD_W-1]}}, right_in});
    assign lim  = $signed({{(LIM_W-THR_W){1'b0}}, limit});
    assign nlim = -lim;
    assign d_pq = p - q;
    assign d_qp = q - p;

    // Sign quadrant decides which wheel is clamped; zero wheels pass through
    always_comb begin
        lp = p;
        lq = q;
        if (p > 0 && q > 0) begin
            if (p > q) begin
                if (p > lim) begin
                    lp = lim;
                    lq = lim - d_pq;
                end
            end else begin
                if (q > lim) begin
                    lq = lim;
                    lp = lim - d_qp;
                end
            end
        end else if (p > 0 && q < 0) begin
            if (p >= lim && q <= nlim) begin
                lp = lim;
                lq = nlim;
            end else if (p >= lim) begin
                lp = lim;
                lq = lim - d_pq;
            end else if (q <= nlim) begin
                lp = nlim + d_pq;
                lq = nlim;
            end
        end else if (p < 0 && q > 0) begin
            if (p <= nlim && q >= lim) begin
                lp = nlim;
                lq = lim;
            end else if (q >= lim) begin
                lp = lim - d_qp;
                lq = lim;
            end else if (p <= nlim) begin
                lp = nlim;
                lq = nlim + d_qp;
            end
        end else if (p < 0 && q < 0) begin
            if (p < q) begin
                if (p < nlim) begin
                    lp = nlim;
                    lq = nlim + d_qp;
                end
            end else begin
                if (q < nlim) begin
                    lp = nlim + d_pq;
                    lq = nlim;
                end
            end
        end
    end

    assign left_out  = lp[OUT_W-1:0];
    assign right_out = lq[OUT_W-1:0];

endmodule
